[rtl/tkve_pkg.sv]
package tkve_pkg;

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_PRECOLON,
        PH_POSTCOLON,
        PH_INT_SIGN,
        PH_INT_DIGITS,
        PH_BOOL_T,
        PH_BOOL_F,
        PH_STR,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        REG_KEY_LOW,
        REG_KEY_HIGH,
        REG_KEY_LENGTH,
        REG_VALUE_MODE,
        REG_DEFAULT,
        REG_CAPACITY
    } t_reg_index;

    typedef enum logic [1:0] {
        MODE_INT,
        MODE_BOOL,
        MODE_STRING,
        MODE_UNUSED
    } t_mode;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic [31:0] scalar;
        logic        found;
    } t_result;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_F         = 8'h66;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

    function automatic logic [7:0] word_true_char(input logic [2:0] pos);
        case (pos)
            3'd0: word_true_char = 8'h74;
            3'd1: word_true_char = 8'h72;
            3'd2: word_true_char = 8'h75;
            3'd3: word_true_char = 8'h65;
            default: word_true_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] word_false_char(input logic [2:0] pos);
        case (pos)
            3'd0: word_false_char = 8'h66;
            3'd1: word_false_char = 8'h61;
            3'd2: word_false_char = 8'h6C;
            3'd3: word_false_char = 8'h73;
            3'd4: word_false_char = 8'h65;
            default: word_false_char = 8'h00;
        endcase
    endfunction

endpackage

[rtl/text_key_value_extractor.sv]
// Quoted-key value extractor.
// The body arrives on the s_axis channel, one byte per request, with tlast on the
// last byte. The block finds the first "key" in the body, expects a colon after
// optional blanks, and reads an integer, a boolean or a quoted string by value mode.
// String characters leave on m_axis with tuser 0; each body ends with one final
// request with tuser 1 and tlast 1 carrying the value and the found flag.
// Registers are written on the cfg channel, which is always ready; the user must
// write them only while no body is in flight, as the block does not enforce it.
// Each byte is processed in the cycle it is accepted, and its results are
// registered into a four-entry output queue.
// One byte is accepted every cycle while the queue has two free entries; a byte
// that causes both a character and a final result pushes two queue entries,
// so the output port sets the sustained rate.
// When the receiver stalls, the queue fills and s_axis_tready drops.
// Synchronous reset clears all registers, the match window and the queue.
module text_key_value_extractor
    import tkve_pkg::*;
#(
    parameter int KEY_CHARS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] body_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] text_byte, [39:8] scalar_value, [40] found
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int WIN   = KEY_CHARS + 2;
    localparam int WIN_W = $clog2(WIN);
    localparam int KN    = (KEY_CHARS < 16) ? KEY_CHARS : 16;

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic [4:0]  r_key_length;
    logic [1:0]  r_value_mode;
    logic [31:0] r_default;
    logic [15:0] r_capacity;

    logic [7:0]  r_win [WIN];
    logic [7:0]  n_win [WIN];
    logic [7:0]  w_shift [WIN];
    t_phase      r_phase, n_phase;
    logic [31:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic        r_value_ok, n_value_ok;
    logic [2:0]  r_word_pos, n_word_pos;
    logic [15:0] r_copied, n_copied;
    logic        r_esc, n_esc;

    t_result     r_queue [4];
    logic [1:0]  r_rd_ptr, r_wr_ptr;
    logic [2:0]  r_count;

    logic [127:0] key_bits;
    logic [4:0]   key_lim;
    logic [4:0]   key_len;
    logic         needle_hit;
    logic [7:0]   b;
    logic         accept;
    logic         pop;
    logic         char_valid;
    logic [7:0]   char_byte;
    logic         final_found;
    logic [31:0]  final_scalar;
    logic [35:0]  dig_sum;
    logic [31:0]  dig_mag;
    logic         b_digit;
    logic         b_blank;
    logic [16:0]  copy_next;
    t_result      res_char, res_final;

    assign key_bits      = {r_key_high, r_key_low};
    assign b             = s_axis_tdata;
    assign s_axis_tready = (r_count <= 3'd2);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign b_digit       = (b >= CH_ZERO) && (b <= CH_NINE);
    assign b_blank       = (b == CH_SPACE) || (b == CH_TAB);
    assign dig_sum       = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
                           + {32'b0, b[3:0] - CH_ZERO[3:0]};
    assign dig_mag       = (dig_sum > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : dig_sum[31:0];
    assign copy_next     = {1'b0, r_copied + 16'd1} + 17'd1;

    always_comb begin
        key_lim = (r_key_length > 5'(KN)) ? 5'(KN) : r_key_length;
        key_len = key_lim;
        for (int i = KN - 1; i >= 0; i--) begin
            if ((5'(i) < key_lim) && (key_bits[8*i +: 8] == 8'h00)) begin
                key_len = 5'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WIN - 1; i++) begin
            w_shift[i] = r_win[i + 1];
        end
        w_shift[WIN - 1] = b;
        needle_hit = (w_shift[WIN_W'(WIN - 2) - WIN_W'(key_len)] == CH_QUOTE)
                     && (w_shift[WIN - 1] == CH_QUOTE);
        for (int i = 0; i < KN; i++) begin
            if (5'(i) < key_len) begin
                if (w_shift[WIN_W'(WIN - 1 + i) - WIN_W'(key_len)] != key_bits[8*i +: 8]) begin
                    needle_hit = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_win      = r_win;
        n_phase    = r_phase;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_value_ok = r_value_ok;
        n_word_pos = r_word_pos;
        n_copied   = r_copied;
        n_esc      = r_esc;
        char_valid = 1'b0;
        char_byte  = b;
        final_found  = 1'b0;
        final_scalar = 32'd0;

        if (accept && r_phase != PH_DONE) begin
            if (b == 8'h00) begin
                if (r_phase == PH_STR && r_esc) begin
                    char_valid = 1'b1;
                    char_byte  = CH_BACKSLASH;
                end
                n_esc   = 1'b0;
                n_phase = PH_DONE;
            end else begin
                case (r_phase)
                    PH_SEARCH: begin
                        n_win = w_shift;
                        if (needle_hit) begin
                            n_phase = PH_PRECOLON;
                        end
                    end
                    PH_PRECOLON: begin
                        if (!b_blank) begin
                            n_phase = (b == CH_COLON) ? PH_POSTCOLON : PH_DONE;
                        end
                    end
                    PH_POSTCOLON: begin
                        if (!b_blank) begin
                            n_phase = PH_DONE;
                            case (t_mode'(r_value_mode))
                                MODE_INT: begin
                                    if (b == CH_MINUS || b == CH_PLUS) begin
                                        n_neg   = (b == CH_MINUS);
                                        n_phase = PH_INT_SIGN;
                                    end else if (b_digit) begin
                                        n_mag      = dig_mag;
                                        n_value_ok = 1'b1;
                                        n_phase    = PH_INT_DIGITS;
                                    end
                                end
                                MODE_BOOL: begin
                                    if (b == CH_T) begin
                                        n_word_pos = 3'd1;
                                        n_phase    = PH_BOOL_T;
                                    end else if (b == CH_F) begin
                                        n_word_pos = 3'd1;
                                        n_phase    = PH_BOOL_F;
                                    end
                                end
                                MODE_STRING: begin
                                    if (r_capacity != 16'd0 && b == CH_QUOTE) begin
                                        n_value_ok = 1'b1;
                                        if (r_capacity > 16'd1) begin
                                            n_phase = PH_STR;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    PH_INT_SIGN, PH_INT_DIGITS: begin
                        if (b_digit) begin
                            n_mag      = dig_mag;
                            n_value_ok = 1'b1;
                            n_phase    = PH_INT_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_BOOL_T: begin
                        if (r_word_pos < 3'd4 && b == word_true_char(r_word_pos)) begin
                            n_word_pos = r_word_pos + 3'd1;
                            if (r_word_pos == 3'd3) begin
                                n_mag      = 32'd1;
                                n_value_ok = 1'b1;
                                n_phase    = PH_DONE;
                            end
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_BOOL_F: begin
                        if (r_word_pos < 3'd5 && b == word_false_char(r_word_pos)) begin
                            n_word_pos = r_word_pos + 3'd1;
                            if (r_word_pos == 3'd4) begin
                                n_mag      = 32'd0;
                                n_value_ok = 1'b1;
                                n_phase    = PH_DONE;
                            end
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_STR: begin
                        if (r_esc || (b != CH_QUOTE && b != CH_BACKSLASH)) begin
                            n_esc      = 1'b0;
                            char_valid = 1'b1;
                            n_copied   = r_copied + 16'd1;
                            if (copy_next >= {1'b0, r_capacity}) begin
                                n_phase = PH_DONE;
                            end
                        end else if (b == CH_QUOTE) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_esc = 1'b1;
                        end
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
        end

        if (accept && s_axis_tlast) begin
            if (n_phase == PH_STR && n_esc) begin
                char_valid = 1'b1;
                char_byte  = CH_BACKSLASH;
            end
            final_found = n_value_ok;
            if ((r_value_mode == MODE_STRING && r_capacity == 16'd0)
                || r_value_mode == MODE_UNUSED) begin
                final_found = 1'b0;
            end
            case (t_mode'(r_value_mode))
                MODE_INT: begin
                    if (!final_found) begin
                        final_scalar = r_default;
                    end else if (n_neg) begin
                        final_scalar = (n_mag >= MAG_LIMIT) ? MAG_LIMIT : (32'd0 - n_mag);
                    end else begin
                        final_scalar = (n_mag > POS_LIMIT) ? POS_LIMIT : n_mag;
                    end
                end
                MODE_BOOL:   final_scalar = final_found ? {31'd0, n_mag[0]} : r_default;
                MODE_STRING: final_scalar = 32'd0;
                default:     final_scalar = r_default;
            endcase
            for (int i = 0; i < WIN; i++) begin
                n_win[i] = 8'h00;
            end
            n_phase    = PH_SEARCH;
            n_mag      = 32'd0;
            n_neg      = 1'b0;
            n_value_ok = 1'b0;
            n_word_pos = 3'd0;
            n_copied   = 16'd0;
            n_esc      = 1'b0;
        end
    end

    always_comb begin
        res_char.kind       = 1'b0;
        res_char.text_byte  = char_byte;
        res_char.scalar     = 32'd0;
        res_char.found      = 1'b0;
        res_final.kind      = 1'b1;
        res_final.text_byte = 8'h00;
        res_final.scalar    = final_scalar;
        res_final.found     = final_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= 64'd0;
            r_key_high   <= 64'd0;
            r_key_length <= 5'd0;
            r_value_mode <= 2'd0;
            r_default    <= 32'd0;
            r_capacity   <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_index'(i_cfg_index))
                REG_KEY_LOW:    r_key_low    <= i_cfg_data;
                REG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                REG_KEY_LENGTH: r_key_length <= i_cfg_data[4:0];
                REG_VALUE_MODE: r_value_mode <= i_cfg_data[1:0];
                REG_DEFAULT:    r_default    <= i_cfg_data[31:0];
                REG_CAPACITY:   r_capacity   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN; i++) begin
                r_win[i] <= 8'h00;
            end
            r_phase    <= PH_SEARCH;
            r_mag      <= 32'd0;
            r_neg      <= 1'b0;
            r_value_ok <= 1'b0;
            r_word_pos <= 3'd0;
            r_copied   <= 16'd0;
            r_esc      <= 1'b0;
        end else begin
            r_win      <= n_win;
            r_phase    <= n_phase;
            r_mag      <= n_mag;
            r_neg      <= n_neg;
            r_value_ok <= n_value_ok;
            r_word_pos <= n_word_pos;
            r_copied   <= n_copied;
            r_esc      <= n_esc;
        end
    end

    logic       push_final;
    logic [2:0] push_count;

    assign push_final = accept && s_axis_tlast;
    assign push_count = {2'b0, char_valid} + {2'b0, push_final};

    always_ff @(posedge i_clk) begin
        if (char_valid) begin
            r_queue[r_wr_ptr] <= res_char;
            if (push_final) begin
                r_queue[r_wr_ptr + 2'd1] <= res_final;
            end
        end else if (push_final) begin
            r_queue[r_wr_ptr] <= res_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 2'd0;
            r_wr_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_count[1:0];
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + push_count - {2'b0, pop};
        end
    end

    assign m_axis_tvalid = (r_count != 3'd0);
    assign m_axis_tdata  = {7'd0, r_queue[r_rd_ptr].found, r_queue[r_rd_ptr].scalar,
                            r_queue[r_rd_ptr].text_byte};
    assign m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign m_axis_tlast  = r_queue[r_rd_ptr].kind;

endmodule

[tb/tb_text_key_value_extractor.sv]
module tb_text_key_value_extractor;
    timeunit 1ns;
    timeprecision 1ps;

    import tkve_pkg::*;

    localparam int KEY_CHARS = 16;
    localparam int WIN_DEPTH = KEY_CHARS + 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TARGET_BYTES = 1700;
    localparam int PHASE_BYTES = 120;
    localparam int MAX_REPORTS = 10;
    localparam int LONG_HOLD = 400;
    localparam logic [31:0] WORD_TRUE = "true";
    localparam logic [39:0] WORD_FALSE = "false";

    typedef struct packed {
        logic [7:0] body_byte;
        logic       end_of_body;
    } body_req_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic [31:0] scalar;
        logic        found;
        logic        last;
    } scan_out_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    text_key_value_extractor #(
        .KEY_CHARS(KEY_CHARS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the block's registers and scan state.
    logic [63:0] key_lo = '0;
    logic [63:0] key_hi = '0;
    logic [4:0]  key_len = '0;
    t_mode       val_mode = MODE_INT;
    logic [31:0] dflt_val = '0;
    logic [15:0] str_cap = '0;
    logic [7:0]  win [WIN_DEPTH];
    t_phase      scan_ph;
    logic [31:0] mag;
    logic        neg;
    logic        sat;
    logic        val_ok;
    logic        esc_pend;
    logic [2:0]  word_pos;
    logic [15:0] copied;

    scan_out_t   extracted_q[$];
    body_req_t   body_reqs[$];
    logic [7:0]  body_buf[$];
    body_req_t   tx_req;

    int  cycle_count = 0;
    int  fail_count = 0;
    int  bytes_in = 0;
    int  bytes_queued = 0;
    int  results_out = 0;
    int  bodies_done = 0;
    int  settings_used = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    int  rx_hold = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    bit  byte_taken = 1'b0;
    bit  result_taken = 1'b0;
    bit  stop_here = 1'b0;

    function automatic logic [7:0] key_at(int idx);
        if (idx < 8) return key_lo[8*idx +: 8];
        if (idx < 16) return key_hi[8*(idx-8) +: 8];
        return 8'h00;
    endfunction

    function automatic int key_span();
        int lim;
        int i;
        lim = int'(key_len);
        if (lim > KEY_CHARS) lim = KEY_CHARS;
        if (lim > 16) lim = 16;
        for (i = 0; i < lim; i++)
            if (key_at(i) == 8'h00) return i;
        return lim;
    endfunction

    function automatic logic key_seen();
        int len;
        int base;
        int i;
        len = key_span();
        base = WIN_DEPTH - len - 2;
        if (win[base] != CH_QUOTE || win[WIN_DEPTH-1] != CH_QUOTE) return 1'b0;
        for (i = 0; i < len; i++)
            if (win[base+1+i] != key_at(i)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_scan();
        int i;
        for (i = 0; i < WIN_DEPTH; i++) win[i] = 8'h00;
        scan_ph = PH_SEARCH;
        mag = '0;
        neg = 1'b0;
        sat = 1'b0;
        val_ok = 1'b0;
        esc_pend = 1'b0;
        word_pos = '0;
        copied = '0;
    endfunction

    function automatic void push_out(logic kind, logic [7:0] ch, logic [31:0] scalar,
                                     logic found);
        scan_out_t r;
        r.kind = kind;
        r.text_byte = ch;
        r.scalar = scalar;
        r.found = found;
        r.last = kind;
        extracted_q.push_back(r);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void add_digit(logic [7:0] b);
        logic [63:0] acc;
        acc = {32'h0, mag} * 64'd10 + {56'h0, b - CH_ZERO};
        val_ok = 1'b1;
        if (acc > {32'h0, MAG_LIMIT}) begin
            acc = {32'h0, MAG_LIMIT};
            sat = 1'b1;
        end
        mag = acc[31:0];
    endfunction

    function automatic void copy_char(logic [7:0] b);
        push_out(1'b0, b, '0, 1'b0);
        copied = copied + 16'd1;
        if ({1'b0, copied} + 17'd1 >= {1'b0, str_cap}) scan_ph = PH_DONE;
    endfunction

    function automatic void start_value(logic [7:0] b);
        scan_ph = PH_DONE;
        case (val_mode)
            MODE_INT: begin
                if (b == CH_MINUS || b == CH_PLUS) begin
                    neg = (b == CH_MINUS);
                    scan_ph = PH_INT_SIGN;
                end else if (is_digit(b)) begin
                    add_digit(b);
                    scan_ph = PH_INT_DIGITS;
                end
            end
            MODE_BOOL: begin
                if (b == CH_T) begin
                    word_pos = 3'd1;
                    scan_ph = PH_BOOL_T;
                end else if (b == CH_F) begin
                    word_pos = 3'd1;
                    scan_ph = PH_BOOL_F;
                end
            end
            MODE_STRING: begin
                if (str_cap != 16'd0 && b == CH_QUOTE) begin
                    val_ok = 1'b1;
                    if (str_cap > 16'd1) scan_ph = PH_STR;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void scan_body_byte(logic [7:0] b, logic eob);
        logic        found;
        logic [31:0] scalar;
        int          i;
        if (scan_ph != PH_DONE) begin
            if (b == 8'h00) begin
                if (scan_ph == PH_STR && esc_pend) push_out(1'b0, CH_BACKSLASH, '0, 1'b0);
                esc_pend = 1'b0;
                scan_ph = PH_DONE;
            end else begin
                case (scan_ph)
                    PH_SEARCH: begin
                        for (i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i+1];
                        win[WIN_DEPTH-1] = b;
                        if (key_seen()) scan_ph = PH_PRECOLON;
                    end
                    PH_PRECOLON: begin
                        if (b != CH_SPACE && b != CH_TAB)
                            scan_ph = (b == CH_COLON) ? PH_POSTCOLON : PH_DONE;
                    end
                    PH_POSTCOLON: begin
                        if (b != CH_SPACE && b != CH_TAB) start_value(b);
                    end
                    PH_INT_SIGN, PH_INT_DIGITS: begin
                        if (is_digit(b)) begin
                            add_digit(b);
                            scan_ph = PH_INT_DIGITS;
                        end else begin
                            scan_ph = PH_DONE;
                        end
                    end
                    PH_BOOL_T: begin
                        if (word_pos < 3'd4 && b == WORD_TRUE[8*(3-word_pos) +: 8]) begin
                            word_pos = word_pos + 3'd1;
                            if (word_pos == 3'd4) begin
                                mag = 32'd1;
                                val_ok = 1'b1;
                                scan_ph = PH_DONE;
                            end
                        end else begin
                            scan_ph = PH_DONE;
                        end
                    end
                    PH_BOOL_F: begin
                        if (word_pos < 3'd5 && b == WORD_FALSE[8*(4-word_pos) +: 8]) begin
                            word_pos = word_pos + 3'd1;
                            if (word_pos == 3'd5) begin
                                mag = 32'd0;
                                val_ok = 1'b1;
                                scan_ph = PH_DONE;
                            end
                        end else begin
                            scan_ph = PH_DONE;
                        end
                    end
                    PH_STR: begin
                        if (esc_pend) begin
                            esc_pend = 1'b0;
                            copy_char(b);
                        end else if (b == CH_QUOTE) begin
                            scan_ph = PH_DONE;
                        end else if (b == CH_BACKSLASH) begin
                            esc_pend = 1'b1;
                        end else begin
                            copy_char(b);
                        end
                    end
                    default: scan_ph = PH_DONE;
                endcase
            end
        end
        if (eob) begin
            found = val_ok;
            if (scan_ph == PH_STR && esc_pend) push_out(1'b0, CH_BACKSLASH, '0, 1'b0);
            if ((val_mode == MODE_STRING && str_cap == 16'd0) || val_mode == MODE_UNUSED)
                found = 1'b0;
            case (val_mode)
                MODE_INT: begin
                    if (!found) scalar = dflt_val;
                    else if (neg) scalar = (mag >= MAG_LIMIT) ? MAG_LIMIT : 32'h0 - mag;
                    else scalar = (mag > POS_LIMIT) ? POS_LIMIT : mag;
                end
                MODE_BOOL: scalar = found ? {31'h0, mag[0]} : dflt_val;
                MODE_STRING: scalar = '0;
                default: scalar = dflt_val;
            endcase
            push_out(1'b1, 8'h00, scalar, found);
            clear_scan();
            bodies_done++;
        end
    endfunction

    function automatic void write_reg_model(t_reg_index idx, logic [63:0] data);
        case (idx)
            REG_KEY_LOW: key_lo = data;
            REG_KEY_HIGH: key_hi = data;
            REG_KEY_LENGTH: key_len = data[4:0];
            REG_VALUE_MODE: val_mode = t_mode'(data[1:0]);
            REG_DEFAULT: dflt_val = data[31:0];
            REG_CAPACITY: str_cap = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic void check_result();
        scan_out_t want;
        results_out++;
        if (extracted_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result: kind %0b tdata %h last %0b",
                         m_axis_tuser, m_axis_tdata, m_axis_tlast);
            return;
        end
        want = extracted_q.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.text_byte ||
            m_axis_tdata[39:8] !== want.scalar || m_axis_tdata[40] !== want.found ||
            m_axis_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("mismatch on result %0d: expected kind %0b byte %h value %h found %0b last %0b",
                         results_out, want.kind, want.text_byte, want.scalar, want.found,
                         want.last);
                $display("    got kind %0b byte %h value %h found %0b last %0b",
                         m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tdata[40],
                         m_axis_tlast);
            end
        end
    endfunction

    function automatic int draw_idle(bit steady);
        if (steady || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 12);
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_text_key_value_extractor: errors");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) write_reg_model(t_reg_index'(i_cfg_index), i_cfg_data);
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
                result_taken = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                scan_body_byte(s_axis_tdata, s_axis_tlast);
                byte_taken = 1'b1;
                bytes_in++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!s_axis_tvalid || byte_taken) begin
            if (tx_wait > 0) begin
                tx_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (body_reqs.size() != 0) begin
                tx_req = body_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= tx_req.body_byte;
                s_axis_tlast <= tx_req.end_of_body;
                tx_wait = draw_idle(tx_steady);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        byte_taken = 1'b0;
    end

    always @(negedge i_clk) begin
        if (result_taken) rx_wait = draw_idle(rx_steady);
        result_taken = 1'b0;
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(t_reg_index idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_settings(logic [63:0] lo, logic [63:0] hi, logic [4:0] len, t_mode m,
                                 logic [31:0] dv, logic [15:0] cap);
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
        write_reg(REG_KEY_LENGTH, {59'h0, len});
        write_reg(REG_VALUE_MODE, {62'h0, m});
        write_reg(REG_DEFAULT, {32'h0, dv});
        write_reg(REG_CAPACITY, {48'h0, cap});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        while (body_reqs.size() != 0 || s_axis_tvalid || extracted_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void put_byte(logic [7:0] b);
        body_buf.push_back(b);
    endfunction

    function automatic void put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) body_buf.push_back(s[i]);
    endfunction

    function automatic void commit_body();
        body_req_t r;
        int i;
        if (body_buf.size() == 0) body_buf.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < body_buf.size(); i++) begin
            r.body_byte = body_buf[i];
            r.end_of_body = (i == body_buf.size() - 1);
            body_reqs.push_back(r);
        end
        bytes_queued += body_buf.size();
        body_buf.delete();
    endfunction

    function automatic logic [7:0] noise_byte();
        string pool;
        pool = "ab\" :\t-+09tf\\";
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic void put_blanks();
        repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void put_int();
        case ($urandom_range(0, 3))
            0: put_byte(CH_MINUS);
            1: put_byte(CH_PLUS);
            default: ;
        endcase
        case ($urandom_range(0, 6))
            0: put_text("2147483647");
            1: put_text("2147483648");
            2: put_text("2147483649");
            3: repeat ($urandom_range(11, 14)) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            default: repeat ($urandom_range(0, 6)) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        endcase
    endfunction

    function automatic void put_bool();
        string w;
        w = $urandom_range(0, 1) ? "true" : "false";
        case ($urandom_range(0, 5))
            0, 1, 2, 3: put_text(w);
            4: put_text(w.substr(0, $urandom_range(0, w.len() - 2)));
            default: begin
                put_text(w.substr(0, $urandom_range(0, w.len() - 2)));
                put_byte(noise_byte());
            end
        endcase
    endfunction

    function automatic void put_string();
        put_byte($urandom_range(0, 7) != 0 ? CH_QUOTE : noise_byte());
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 5) == 0) begin
                put_byte(CH_BACKSLASH);
                put_byte(8'($urandom_range(1, 255)));
            end else begin
                put_byte(8'($urandom_range(1, 255)));
            end
        end
        case ($urandom_range(0, 5))
            0: begin
                put_byte(CH_BACKSLASH);
                stop_here = 1'b1;
            end
            1: begin
                put_byte(CH_BACKSLASH);
                put_byte(8'h00);
            end
            default: put_byte(CH_QUOTE);
        endcase
    endfunction

    function automatic void build_body();
        int len;
        int bad;
        int k;
        int cut;
        t_mode m;
        stop_here = 1'b0;
        len = key_span();
        repeat ($urandom_range(0, 3)) put_byte(noise_byte());
        if ($urandom_range(0, 9) != 0) begin
            bad = (len != 0 && $urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
            put_byte(CH_QUOTE);
            for (k = 0; k < len; k++) put_byte(k == bad ? key_at(k) ^ 8'h01 : key_at(k));
            put_byte(CH_QUOTE);
            put_blanks();
            put_byte($urandom_range(0, 9) != 0 ? CH_COLON : noise_byte());
            put_blanks();
            m = ($urandom_range(0, 5) == 0) ? t_mode'($urandom_range(0, 2)) : val_mode;
            case (m)
                MODE_BOOL: put_bool();
                MODE_STRING: put_string();
                default: put_int();
            endcase
        end
        if (!stop_here) begin
            repeat ($urandom_range(0, 3)) put_byte(noise_byte());
            if (body_buf.size() > 1 && $urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, body_buf.size() - 1);
                while (body_buf.size() > cut) void'(body_buf.pop_back());
            end
            if (body_buf.size() != 0 && $urandom_range(0, 11) == 0)
                body_buf[$urandom_range(0, body_buf.size() - 1)] = 8'h00;
        end
        commit_body();
    endfunction

    task automatic random_settings(int p);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [31:0] dv;
        logic [15:0] cap;
        logic [7:0]  c;
        t_mode       m;
        int          k;
        int          style;
        m = t_mode'(p % 4);
        style = $urandom_range(0, 5);
        for (k = 0; k < 16; k++) begin
            if (p == 1) c = 8'hFF;
            else if (style == 0) c = 8'($urandom_range(1, 255));
            else c = "a" + 8'($urandom_range(0, 25));
            if (k < 8) lo[8*k +: 8] = c;
            else hi[8*(k-8) +: 8] = c;
        end
        if ($urandom_range(0, 7) == 0) begin
            k = $urandom_range(0, 15);
            if (k < 8) lo[8*k +: 8] = 8'h00;
            else hi[8*(k-8) +: 8] = 8'h00;
        end
        case ((p < 6) ? p : $urandom_range(0, 5))
            0: len = 5'd0;
            1: len = 5'd16;
            2: len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 4))
            0: dv = MAG_LIMIT;
            1: dv = POS_LIMIT;
            2: dv = '0;
            default: dv = $urandom();
        endcase
        if (m != MODE_STRING) begin
            cap = 16'($urandom());
        end else begin
            case ((p < 16) ? p / 4 : $urandom_range(0, 4))
                0: cap = 16'hFFFF;
                2: cap = 16'd0;
                3: cap = 16'($urandom_range(1, 2));
                default: cap = 16'($urandom_range(3, 12));
            endcase
        end
        load_settings(lo, hi, len, m, dv, cap);
    endtask

    initial begin
        int p;
        clear_scan();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Short directed bodies: a signed integer cut by a letter, sign without digits,
        // zero byte, partial boolean, and a string that ends on a backslash.
        load_settings(64'h6B, 64'h0, 5'd1, MODE_INT, MAG_LIMIT, 16'd0);
        put_text("\"k\":-7x");
        commit_body();
        put_text("\"k\":-");
        commit_body();
        put_byte(8'h00);
        commit_body();
        drain();
        load_settings(64'h6B, 64'h0, 5'd1, MODE_BOOL, POS_LIMIT, 16'd0);
        put_text("\"k\":fals");
        commit_body();
        drain();
        load_settings(64'h6B, 64'h0, 5'd1, MODE_STRING, 32'h0, 16'd3);
        put_text("\"k\":\"a\\");
        commit_body();
        drain();

        p = 0;
        while (bytes_queued < TARGET_BYTES) begin
            random_settings(p);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            while (body_reqs.size() < PHASE_BYTES) build_body();
            if (p == 3) begin
                @(posedge i_clk);
                tx_steady = 1'b1;
                rx_hold = LONG_HOLD;
            end
            drain();
            p++;
        end

        repeat (8) @(posedge i_clk);
        if (extracted_q.size() != 0) begin
            $display("%0d expected results never arrived", extracted_q.size());
            fail_count += extracted_q.size();
        end
        $display("run: %0d body bytes in %0d bodies, %0d results, %0d register settings",
                 bytes_in, bodies_done, results_out, settings_used);
        $display("run: integer, boolean, string and unused modes, one long output stall");
        if (fail_count == 0) begin
            $display("tb_text_key_value_extractor: clean");
        end else begin
            $display("tb_text_key_value_extractor: errors");
        end
        $finish;
    end

endmodule
